// ===== rtl/tssms_pkg.sv =====
// Package for the two-sample shift median block.
// Shared constants and small arithmetic helpers; no dependencies.
`default_nettype none

package tssms_pkg;

	localparam int DEF_MAX_FIRST  = 64;
	localparam int DEF_MAX_SECOND = 64;

	// Bound on partition passes; valid data ends well before it
	localparam int SEARCH_CAP = 65536;

	localparam logic [15:0] LFSR_SEED = 16'hACE1;
	localparam logic [15:0] LFSR_MASK = 16'hB400;

	localparam int VAL_W = 32;
	localparam int RES_W = 35;

	typedef logic signed [32:0]      diff_t;
	typedef logic signed [RES_W-1:0] res_t;

	function automatic diff_t sdiff(logic [VAL_W-1:0] a, logic [VAL_W-1:0] b);
		sdiff = $signed({a[VAL_W-1], a}) - $signed({b[VAL_W-1], b});
	endfunction

	function automatic res_t dbl(diff_t d);
		dbl = $signed({d[32], d, 1'b0});
	endfunction

	function automatic res_t wide(diff_t d);
		wide = $signed({{2{d[32]}}, d});
	endfunction

	function automatic res_t sx(logic [VAL_W-1:0] a);
		sx = $signed({{3{a[VAL_W-1]}}, a});
	endfunction

endpackage

`default_nettype wire

// ===== rtl/two_sample_shift_median_select.sv =====
// Two-sample shift estimator: sorted sample stores and partition search.
// Depends on tssms_pkg and tssms_div.
//
// Each transfer on the item channel adds one value to sample x (func 0) or
// sample y (func 1); the value is insertion-sorted into its store, which holds
// off the next transfer while each larger value already stored is shifted up.
// A value for a full store is dropped. The transfer with last_item set also
// starts the search and yields one result: twice the median of all pairwise
// differences x[i]-y[j], with empty_set raised (and the estimate zero) if a
// sample was empty; both counts then clear for the next data set. The search
// runs on single-read-port memories for the stores and the per-row bounds, so
// its time is set by memory reads in the partition passes, bound updates and
// pivot picks; the initial bounds of each row and the random pivot picks come
// from the shared serial divider (W is the divider width, at least 16).
// Items are taken one at a time; the next item is accepted while a result
// still waits on the result channel.
`default_nettype none

module two_sample_shift_median_select #(
	parameter int MAX_FIRST  = tssms_pkg::DEF_MAX_FIRST,
	parameter int MAX_SECOND = tssms_pkg::DEF_MAX_SECOND
) (
	input  wire logic                  clk,
	input  wire logic                  arst_n,
	input  wire logic                  item_valid,
	output logic                       item_stall,
	input  wire logic                  func,
	input  wire logic signed [31:0]    sample_value,
	input  wire logic                  last_item,
	output logic                       result_valid,
	input  wire logic                  result_stall,
	output logic signed [33:0]         median_times_two,
	output logic                       empty_set
);

	import tssms_pkg::*;

	localparam int MAX_ANY = (MAX_FIRST > MAX_SECOND) ? MAX_FIRST : MAX_SECOND;
	localparam int CW  = $clog2(MAX_ANY + 2);
	localparam int NW  = 2 * CW;
	localparam int SW  = NW + 2;
	localparam int DW  = (NW > 16) ? NW : 16;
	localparam int AX  = $clog2(MAX_FIRST);
	localparam int AY  = $clog2(MAX_SECOND);
	localparam int PW  = $clog2(SEARCH_CAP + 1);

	localparam logic [1:0] M_MED = 2'd1;
	localparam logic [1:0] M_MID = 2'd2;
	localparam logic [1:0] M_RND = 2'd3;

	localparam logic [5:0] ST_IDLE = 6'd0,  ST_INS  = 6'd1,  ST_ICMP = 6'd2,  ST_POST = 6'd3;
	localparam logic [5:0] ST_SETUP= 6'd4,  ST_N1A  = 6'd5,  ST_N1B  = 6'd6,  ST_N1C  = 6'd7;
	localparam logic [5:0] ST_M1A  = 6'd8,  ST_M1B  = 6'd9,  ST_M1C  = 6'd10, ST_IB1  = 6'd11;
	localparam logic [5:0] ST_IB2  = 6'd12, ST_IB3  = 6'd13, ST_IB4  = 6'd14, ST_PIV  = 6'd15;
	localparam logic [5:0] ST_P1B  = 6'd16, ST_RW   = 6'd17, ST_RA   = 6'd18, ST_RB   = 6'd19;
	localparam logic [5:0] ST_RC   = 6'd20, ST_RD   = 6'd21, ST_E0   = 6'd22, ST_E1   = 6'd23;
	localparam logic [5:0] ST_E2   = 6'd24, ST_A2   = 6'd25, ST_B2   = 6'd26, ST_C2   = 6'd27;
	localparam logic [5:0] ST_D2   = 6'd28, ST_END2 = 6'd29, ST_PART = 6'd30, ST_PA   = 6'd31;
	localparam logic [5:0] ST_PB   = 6'd32, ST_PJ   = 6'd33, ST_PC   = 6'd34, ST_PEND = 6'd35;
	localparam logic [5:0] ST_UA   = 6'd36, ST_UB   = 6'd37, ST_UEND = 6'd38, ST_PASS = 6'd39;
	localparam logic [5:0] ST_FA   = 6'd40, ST_FB   = 6'd41, ST_FC   = 6'd42, ST_FD   = 6'd43;
	localparam logic [5:0] ST_FE   = 6'd44, ST_FEND = 6'd45, ST_OUT  = 6'd46;

	// memories
	logic [31:0]   x_mem  [MAX_FIRST];
	logic [31:0]   y_mem  [MAX_SECOND];
	logic [CW-1:0] lb_mem [MAX_SECOND];
	logic [CW-1:0] rb_mem [MAX_SECOND];
	logic [CW-1:0] q_mem  [MAX_SECOND];

	logic [31:0]   x_rd, y_rd;
	logic [CW-1:0] lb_rd, rb_rd, q_rd;
	logic [NW-1:0] x_ra_w, y_ra_w;
	logic          x_we, y_we, lb_we, rb_we, q_we;
	logic [31:0]   st_wd;
	logic [CW-1:0] lb_wd, rb_wd, q_wd;

	// control
	logic [5:0]    state_q, state_d;
	logic [CW-1:0] x_cnt_q, y_cnt_q;
	logic [15:0]   lfsr_q, lfsr_nx;
	logic          res_valid_q;

	// datapath
	logic                 func_q, last_q;
	logic [31:0]          value_q;
	logic [CW-1:0]        pos_q, row_q, col_q;
	logic [NW-1:0]        nn_q, k1_q, k2_q, sq_q, quot1_q;
	logic [31:0]          yi_q;
	logic [CW-1:0]        lbv_q, rbv_q, qv_q;
	res_t                 am2_q, res_q;
	diff_t                amx_q, amn_q;
	logic signed [SW-1:0] l_q, sm_q, k_q;
	logic [1:0]           method_q;
	logic [PW-1:0]        pass_q;
	logic                 fin_q, upd_hi_q, empty_q;
	logic signed [33:0]   med_q;
	logic                 emp_q;

	// divider
	logic          div_start, div_done;
	logic [DW-1:0] div_num, div_den, div_quo, div_rem;

	// combinational helpers
	logic                 accept, sel_full, gt, row_last, can_load, brk, part_lt, hit, ret;
	logic [31:0]          sel_rd;
	diff_t                xy_d, xi_d;
	res_t                 am_sum, am2v, fin_res;
	logic signed [SW-1:0] d_rl, lo_s;
	logic [CW-1:0]        lo_c, hi_c, new_lb, new_rb, col_c;
	logic [CW:0]          half, mh, nh;

	tssms_div #(.W(DW)) u_div (
		.clk    (clk),
		.arst_n (arst_n),
		.start  (div_start),
		.num    (div_num),
		.den    (div_den),
		.done   (div_done),
		.quo    (div_quo),
		.rem    (div_rem)
	);

	always_ff @(posedge clk) begin
		if (x_we) begin
			x_mem[pos_q[AX-1:0]] <= st_wd;
		end
		x_rd <= x_mem[x_ra_w[AX-1:0]];
	end

	always_ff @(posedge clk) begin
		if (y_we) begin
			y_mem[pos_q[AY-1:0]] <= st_wd;
		end
		y_rd <= y_mem[y_ra_w[AY-1:0]];
	end

	always_ff @(posedge clk) begin
		if (lb_we) begin
			lb_mem[row_q[AY-1:0]] <= lb_wd;
		end
		if (rb_we) begin
			rb_mem[row_q[AY-1:0]] <= rb_wd;
		end
		if (q_we) begin
			q_mem[row_q[AY-1:0]] <= q_wd;
		end
		lb_rd <= lb_mem[row_q[AY-1:0]];
		rb_rd <= rb_mem[row_q[AY-1:0]];
		q_rd  <= q_mem[row_q[AY-1:0]];
	end

	assign accept     = item_valid && !item_stall;
	assign item_stall = (state_q != ST_IDLE);
	assign can_load   = !res_valid_q || !result_stall;

	always_comb begin
		sel_full = func_q ? (y_cnt_q >= CW'(MAX_SECOND)) : (x_cnt_q >= CW'(MAX_FIRST));
		sel_rd   = func_q ? y_rd : x_rd;
		gt       = $signed(sel_rd) > $signed(value_q);
		row_last = (row_q == y_cnt_q - CW'(1));
		lfsr_nx  = {1'b0, lfsr_q[15:1]} ^ (lfsr_q[0] ? LFSR_MASK : 16'h0000);

		xy_d = sdiff(x_rd, y_rd);
		xi_d = sdiff(x_rd, yi_q);

		am_sum = wide(amx_q) + wide(amn_q);
		// guard against a midpoint that falls outside the half-open interval (amn_q, amx_q]
		if (am_sum <= dbl(amn_q) || am_sum > dbl(amx_q)) begin
			am2v = dbl(amx_q);
		end else begin
			am2v = am_sum;
		end
		ret = (amn_q == amx_q) || (sm_q == $signed(SW'(2)));

		d_rl = $signed(SW'(rb_rd) - SW'(lb_rd));
		brk  = (k_q <= d_rl) || row_last;

		lo_s = $signed(SW'(x_cnt_q) + SW'(1) - SW'(quot1_q));
		lo_c = (lo_s < $signed(SW'(1))) ? CW'(1) : lo_s[CW-1:0];
		hi_c = (NW'(div_quo) > NW'(x_cnt_q)) ? x_cnt_q : CW'(div_quo);

		new_lb = upd_hi_q ? lb_rd : CW'(q_rd + CW'(1));
		new_rb = upd_hi_q ? q_rd : rb_rd;

		half = ((CW+1)'(lbv_q) + (CW+1)'(rbv_q)) >> 1;
		if (half == '0) begin
			col_c = '0;
		end else if (half > (CW+1)'(x_cnt_q)) begin
			col_c = x_cnt_q - CW'(1);
		end else begin
			col_c = CW'(half - (CW+1)'(1));
		end
		mh = ((CW+1)'(x_cnt_q) + (CW+1)'(1)) >> 1;
		nh = ((CW+1)'(y_cnt_q) + (CW+1)'(1)) >> 1;

		part_lt = dbl(xi_d) < am2_q;
		hit     = (sq_q == k2_q - NW'(1)) || (sq_q == k1_q);

		if (k1_q < k2_q) begin
			fin_res = wide(amn_q) + wide(amx_q);
		end else if (sq_q == k1_q) begin
			fin_res = dbl(amx_q);
		end else if (sq_q == k1_q - NW'(1)) begin
			fin_res = dbl(amn_q);
		end else begin
			fin_res = wide(amn_q) + wide(amx_q);
		end
	end

	// memory ports, divider start and next state
	always_comb begin
		x_ra_w    = '0;
		y_ra_w    = '0;
		x_we      = 1'b0;
		y_we      = 1'b0;
		lb_we     = 1'b0;
		rb_we     = 1'b0;
		q_we      = 1'b0;
		st_wd     = value_q;
		lb_wd     = new_lb;
		rb_wd     = new_rb;
		q_wd      = col_q;
		div_start = 1'b0;
		div_num   = DW'(k2_q);
		div_den   = DW'(y_cnt_q - row_q);
		state_d   = state_q;

		unique case (state_q)
			ST_IDLE: begin
				if (accept) state_d = ST_INS;
			end
			ST_INS: begin
				if (func_q) y_ra_w = NW'(pos_q - CW'(1));
				else        x_ra_w = NW'(pos_q - CW'(1));
				if (sel_full) begin
					state_d = ST_POST;
				end else if (pos_q == '0) begin
					x_we    = !func_q;
					y_we    = func_q;
					state_d = ST_POST;
				end else begin
					state_d = ST_ICMP;
				end
			end
			ST_ICMP: begin
				// shift the larger value up, or drop the new one in place
				x_we  = !func_q;
				y_we  = func_q;
				st_wd = gt ? sel_rd : value_q;
				state_d = gt ? ST_INS : ST_POST;
			end
			ST_POST: begin
				if (!last_q) state_d = ST_IDLE;
				else if (x_cnt_q == '0 || y_cnt_q == '0) state_d = ST_OUT;
				else state_d = ST_SETUP;
			end
			ST_SETUP: begin
				if (y_cnt_q == CW'(1))      state_d = ST_N1A;
				else if (x_cnt_q == CW'(1)) state_d = ST_M1A;
				else                        state_d = ST_IB1;
			end
			ST_N1A: begin
				x_ra_w  = k1_q - NW'(1);
				state_d = ST_N1B;
			end
			ST_N1B: begin
				x_ra_w  = k2_q - NW'(1);
				state_d = ST_N1C;
			end
			ST_N1C: state_d = ST_OUT;
			ST_M1A: begin
				y_ra_w  = k1_q - NW'(1);
				state_d = ST_M1B;
			end
			ST_M1B: begin
				y_ra_w  = k2_q - NW'(1);
				state_d = ST_M1C;
			end
			ST_M1C: state_d = ST_OUT;
			ST_IB1: begin
				div_start = 1'b1;
				div_num   = DW'(nn_q + NW'(1) - k1_q);
				div_den   = DW'(row_q + CW'(1));
				state_d   = ST_IB2;
			end
			ST_IB2: begin
				if (div_done) state_d = ST_IB3;
			end
			ST_IB3: begin
				div_start = 1'b1;
				state_d   = ST_IB4;
			end
			ST_IB4: begin
				lb_wd = lo_c;
				rb_wd = hi_c;
				if (div_done) begin
					lb_we   = 1'b1;
					rb_we   = 1'b1;
					state_d = row_last ? ST_PIV : ST_IB1;
				end
			end
			ST_PIV: begin
				x_ra_w = NW'(mh) - NW'(1);
				y_ra_w = NW'(nh) - NW'(1);
				div_num = DW'(lfsr_nx);
				div_den = DW'(sm_q[NW-1:0]);
				case (method_q)
					M_MED: state_d = ST_P1B;
					M_MID: state_d = ST_E0;
					default: begin
						if (sm_q > 0) begin
							div_start = 1'b1;
							state_d   = ST_RW;
						end else begin
							state_d = ST_RA;
						end
					end
				endcase
			end
			ST_P1B: state_d = ST_PART;
			ST_RW: begin
				if (div_done) state_d = ST_RA;
			end
			ST_RA: state_d = ST_RB;
			ST_RB: state_d = brk ? ST_RC : ST_RA;
			ST_RC: begin
				x_ra_w  = NW'(col_c);
				y_ra_w  = NW'(row_q);
				state_d = ST_RD;
			end
			ST_RD: state_d = ST_PART;
			ST_E0: begin
				y_ra_w  = NW'(y_cnt_q - CW'(1));
				state_d = ST_E1;
			end
			ST_E1: begin
				x_ra_w  = NW'(x_cnt_q - CW'(1));
				state_d = ST_E2;
			end
			ST_E2: state_d = fin_q ? ST_FA : ST_A2;
			ST_A2: begin
				y_ra_w  = NW'(row_q);
				state_d = ST_B2;
			end
			ST_B2: begin
				x_ra_w = NW'(lb_rd - CW'(1));
				if (lb_rd <= rb_rd) state_d = ST_C2;
				else                state_d = row_last ? ST_END2 : ST_A2;
			end
			ST_C2: begin
				x_ra_w  = NW'(rbv_q - CW'(1));
				state_d = ST_D2;
			end
			ST_D2: state_d = row_last ? ST_END2 : ST_A2;
			ST_END2: state_d = ret ? ST_OUT : ST_PART;
			ST_PART: state_d = ST_PA;
			ST_PA: begin
				y_ra_w  = NW'(row_q);
				state_d = ST_PB;
			end
			ST_PB: state_d = ST_PJ;
			ST_PJ: begin
				x_ra_w = NW'(col_q);
				if (col_q < x_cnt_q) begin
					state_d = ST_PC;
				end else begin
					q_we    = 1'b1;
					state_d = row_last ? ST_PEND : ST_PA;
				end
			end
			ST_PC: begin
				if (part_lt) begin
					state_d = ST_PJ;
				end else begin
					q_we    = 1'b1;
					state_d = row_last ? ST_PEND : ST_PA;
				end
			end
			ST_PEND: begin
				if ($signed(SW'(sq_q)) == l_q) state_d = ST_PASS;
				else if (hit)                  state_d = ST_E0;
				else                           state_d = ST_UA;
			end
			ST_UA: state_d = ST_UB;
			ST_UB: begin
				lb_we   = 1'b1;
				rb_we   = 1'b1;
				state_d = row_last ? ST_UEND : ST_UA;
			end
			ST_UEND: state_d = ST_PASS;
			ST_PASS: begin
				state_d = (pass_q == PW'(SEARCH_CAP - 1)) ? ST_E0 : ST_PIV;
			end
			ST_FA: begin
				y_ra_w  = NW'(row_q);
				state_d = ST_FB;
			end
			ST_FB: begin
				x_ra_w  = NW'(q_rd - CW'(1));
				state_d = (q_rd != '0) ? ST_FC : ST_FD;
			end
			ST_FC: state_d = ST_FD;
			ST_FD: begin
				x_ra_w = NW'(qv_q);
				if (qv_q < x_cnt_q) state_d = ST_FE;
				else                state_d = row_last ? ST_FEND : ST_FA;
			end
			ST_FE: state_d = row_last ? ST_FEND : ST_FA;
			ST_FEND: state_d = ST_OUT;
			ST_OUT: begin
				if (can_load) state_d = ST_IDLE;
			end
			default: state_d = ST_IDLE;
		endcase
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			state_q     <= ST_IDLE;
			x_cnt_q     <= '0;
			y_cnt_q     <= '0;
			lfsr_q      <= LFSR_SEED;
			res_valid_q <= 1'b0;
		end else begin
			state_q <= state_d;
			if ((state_q == ST_INS && !sel_full && pos_q == '0) ||
			    (state_q == ST_ICMP && !gt)) begin
				if (func_q) y_cnt_q <= y_cnt_q + CW'(1);
				else        x_cnt_q <= x_cnt_q + CW'(1);
			end
			if (state_q == ST_PIV && method_q == M_RND) begin
				lfsr_q <= lfsr_nx;
			end
			if (state_q == ST_OUT && can_load) begin
				res_valid_q <= 1'b1;
				x_cnt_q     <= '0;
				y_cnt_q     <= '0;
			end else if (!result_stall) begin
				res_valid_q <= 1'b0;
			end
		end
	end

	always_ff @(posedge clk) begin
		case (state_q)
			ST_IDLE: begin
				func_q  <= func;
				value_q <= sample_value;
				last_q  <= last_item;
				pos_q   <= func ? y_cnt_q : x_cnt_q;
			end
			ST_ICMP: begin
				if (gt) pos_q <= pos_q - CW'(1);
			end
			ST_POST: begin
				nn_q    <= NW'(x_cnt_q) * NW'(y_cnt_q);
				empty_q <= (x_cnt_q == '0) || (y_cnt_q == '0);
				res_q   <= '0;
			end
			ST_SETUP: begin
				k1_q     <= (nn_q + NW'(1)) >> 1;
				k2_q     <= (nn_q + NW'(2)) >> 1;
				method_q <= M_MED;
				sm_q     <= $signed(SW'(nn_q));
				l_q      <= '0;
				sq_q     <= '0;
				pass_q   <= '0;
				row_q    <= '0;
			end
			ST_N1B: res_q <= sx(x_rd) - (sx(y_rd) <<< 1);
			ST_N1C: res_q <= res_q + sx(x_rd);
			ST_M1B: res_q <= (sx(x_rd) <<< 1) - sx(y_rd);
			ST_M1C: res_q <= res_q - sx(y_rd);
			ST_IB2: begin
				if (div_done) quot1_q <= NW'(div_quo);
			end
			ST_IB4: begin
				if (div_done && !row_last) row_q <= row_q + CW'(1);
			end
			ST_PIV: begin
				fin_q <= 1'b0;
				k_q   <= '0;
				row_q <= '0;
			end
			ST_P1B: am2_q <= dbl(xy_d);
			ST_RW: begin
				if (div_done) k_q <= $signed(SW'(div_rem));
			end
			ST_RB: begin
				lbv_q <= lb_rd;
				rbv_q <= rb_rd;
				if (!brk) begin
					k_q   <= k_q - d_rl - $signed(SW'(1));
					row_q <= row_q + CW'(1);
				end
			end
			ST_RD: am2_q <= dbl(xy_d);
			ST_E1: amx_q <= xy_d;
			ST_E2: begin
				amn_q <= xy_d;
				row_q <= '0;
			end
			ST_B2: begin
				yi_q  <= y_rd;
				lbv_q <= lb_rd;
				rbv_q <= rb_rd;
				if (!(lb_rd <= rb_rd) && !row_last) row_q <= row_q + CW'(1);
			end
			ST_C2: begin
				if (xi_d < amn_q) amn_q <= xi_d;
			end
			ST_D2: begin
				if (xi_d > amx_q) amx_q <= xi_d;
				if (!row_last) row_q <= row_q + CW'(1);
			end
			ST_END2: begin
				am2_q <= am2v;
				res_q <= am2v;
			end
			ST_PART: begin
				row_q <= '0;
				col_q <= '0;
				sq_q  <= '0;
			end
			ST_PB: yi_q <= y_rd;
			ST_PJ: begin
				if (!(col_q < x_cnt_q)) begin
					sq_q <= sq_q + NW'(col_q);
					if (!row_last) row_q <= row_q + CW'(1);
				end
			end
			ST_PC: begin
				if (part_lt) begin
					col_q <= col_q + CW'(1);
				end else begin
					sq_q <= sq_q + NW'(col_q);
					if (!row_last) row_q <= row_q + CW'(1);
				end
			end
			ST_PEND: begin
				if ($signed(SW'(sq_q)) == l_q) begin
					method_q <= M_MID;
				end else if (hit) begin
					fin_q <= 1'b1;
				end else begin
					upd_hi_q <= (sq_q > k1_q);
					row_q    <= '0;
					l_q      <= '0;
					sm_q     <= '0;
				end
			end
			ST_UB: begin
				l_q  <= l_q + $signed(SW'(new_lb)) - $signed(SW'(1));
				sm_q <= sm_q + $signed(SW'(new_rb)) - $signed(SW'(new_lb)) + $signed(SW'(1));
				if (!row_last) row_q <= row_q + CW'(1);
			end
			ST_UEND: begin
				method_q <= (sm_q == $signed(SW'(2))) ? M_MID : M_RND;
			end
			ST_PASS: begin
				pass_q <= pass_q + PW'(1);
				if (pass_q == PW'(SEARCH_CAP - 1)) fin_q <= 1'b1;
				if (sm_q == $signed(SW'(2))) method_q <= M_MID;
			end
			ST_FB: begin
				qv_q <= q_rd;
				yi_q <= y_rd;
			end
			ST_FC: begin
				if (xi_d > amx_q) amx_q <= xi_d;
			end
			ST_FD: begin
				if (!(qv_q < x_cnt_q) && !row_last) row_q <= row_q + CW'(1);
			end
			ST_FE: begin
				if (xi_d < amn_q) amn_q <= xi_d;
				if (!row_last) row_q <= row_q + CW'(1);
			end
			ST_FEND: res_q <= fin_res;
			ST_OUT: begin
				if (can_load) begin
					med_q <= res_q[33:0];
					emp_q <= empty_q;
				end
			end
			default: begin
			end
		endcase
		if (state_q == ST_SETUP) empty_q <= 1'b0;
	end

	assign result_valid     = res_valid_q;
	assign median_times_two = med_q;
	assign empty_set        = emp_q;

endmodule

`default_nettype wire

// ===== rtl/tssms_div.sv =====
// Iterative unsigned divider, one quotient bit per cycle.
// Standalone; used by the shift median block for row bounds and pivot picks.
`default_nettype none

module tssms_div #(
	parameter int W = 16
) (
	input  wire logic         clk,
	input  wire logic         arst_n,
	input  wire logic         start,
	input  wire logic [W-1:0] num,
	input  wire logic [W-1:0] den,
	output logic              done,
	output logic [W-1:0]      quo,
	output logic [W-1:0]      rem
);

	localparam int CNT_W = $clog2(W + 1);

	logic             busy_q;
	logic [CNT_W-1:0] cnt_q;
	logic             done_q;
	logic [W-1:0]     quo_q;
	logic [W-1:0]     rem_q;
	logic [W-1:0]     den_q;
	logic [W:0]       shifted;
	logic             fits;

	assign shifted = {rem_q, quo_q[W-1]};
	assign fits    = (shifted >= {1'b0, den_q});

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			busy_q <= 1'b0;
			cnt_q  <= '0;
			done_q <= 1'b0;
		end else begin
			done_q <= 1'b0;
			if (start) begin
				busy_q <= 1'b1;
				cnt_q  <= CNT_W'(W);
			end else if (busy_q) begin
				cnt_q <= cnt_q - CNT_W'(1);
				if (cnt_q == CNT_W'(1)) begin
					busy_q <= 1'b0;
					done_q <= 1'b1;
				end
			end
		end
	end

	always_ff @(posedge clk) begin
		if (start) begin
			quo_q <= num;
			rem_q <= '0;
			den_q <= den;
		end else if (busy_q) begin
			if (fits) begin
				rem_q <= W'(shifted - {1'b0, den_q});
				quo_q <= {quo_q[W-2:0], 1'b1};
			end else begin
				rem_q <= shifted[W-1:0];
				quo_q <= {quo_q[W-2:0], 1'b0};
			end
		end
	end

	assign done = done_q;
	assign quo  = quo_q;
	assign rem  = rem_q;

endmodule

`default_nettype wire
